// ===== src/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared widths, codes and the word scan result type of the page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // One memory row holds the used bits of this many pages.
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    // Page numbers, counts and the cursor are carried in this many bits.
    localparam int PAGE_W    = 13;
    localparam int ROW_W     = PAGE_W - BIT_W;
    localparam int IDX_W     = 12;

    localparam int DEF_PAGES = 4096;
    localparam logic [PAGE_W-1:0] TOP_PAGE_RESET = 13'd4096;

    // Operation codes carried on the input side.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Register index, taken from the word address bit of the register port.
    localparam logic REG_TOP_PAGE = 1'b0;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_NOMEM   = 2'd2
    } status_t;

    // What the scan of one row reports back to the sequencer.
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] hit_bit;
        logic             all_free;
        logic [BIT_W-1:0] top_free;
    } scan_res_t;

endpackage

// ===== src/bitmap_page_allocator_core.sv =====
`timescale 1ns / 1ps
// Steps: an allocate item scans rows from the cursor up to the search bound and,
//   if no run fits, again from page 0 up to the old cursor, then reads and
//   writes back each row that it marks; a free item reads and writes back each
//   row that it clears; ignored items and allocations under a zero bound go straight to the result.
// Throughput: one item at a time; a new item is taken only in the idle state.
// Reset: after rst_n the used map is swept to all used, one row per cycle,
//   while no item is accepted.
// ----------------------------------------------------------------------------
// Bitmap page allocator core
// Next-fit allocator of contiguous page runs over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
    parameter int PAGES = bpa_pkg::DEF_PAGES
) (
    input  logic        clk,
    input  logic        rst_n,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [11:0] page_index, [24:12] page_count
    input  logic [0:0]  s_tuser,   // [0] mode
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] base_page
    output logic [1:0]  m_tuser    // [1:0] status
);
    import bpa_pkg::*;

    // The used map lives in a memory of ROWS words of 32 pages each. Pages at
    // or above the search bound are never searched, marked or cleared.
    localparam int ROWS      = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PAGES_CAP = (PAGES < (1 << PAGE_W)) ? PAGES : ((1 << PAGE_W) - 1);

    typedef enum logic [6:0] {
        S_CLEAR      = 7'b0000001,
        S_IDLE       = 7'b0000010,
        S_SCAN_START = 7'b0000100,
        S_SCAN       = 7'b0001000,
        S_FILL_RD    = 7'b0010000,
        S_FILL_WR    = 7'b0100000,
        S_DONE       = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [RW-1:0]      clr_row_reg, clr_row_next;
    logic [PAGE_W-1:0]  top_reg, top_next;
    logic [PAGE_W-1:0]  cursor_reg, cursor_next;
    logic               mode_reg, mode_next;
    logic [PAGE_W-1:0]  cnt_reg, cnt_next;
    logic               pass_reg, pass_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PAGE_W-1:0]  from_reg, from_next;
    logic [PAGE_W-1:0]  lm1_reg, lm1_next;
    logic [PAGE_W-1:0]  run_reg, run_next;
    logic [ROW_W-1:0]   fill_row_reg, fill_row_next;
    logic [PAGE_W-1:0]  fill_lo_reg, fill_lo_next;
    logic [PAGE_W-1:0]  fill_hm1_reg, fill_hm1_next;
    status_t            res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_base_reg, res_base_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [IDX_W-1:0]   out_base_reg, out_base_next;

    // Used map memory: one write and one registered read per cycle.
    logic [WORD_BITS-1:0] mem [ROWS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [RW-1:0]        rd_addr;
    logic                 mem_we;
    logic [RW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [WORD_BITS-1:0] eff_used;
    logic [PAGE_W-1:0]    deficit;
    logic [PAGE_W-1:0]    lim;
    scan_res_t            sres;
    logic                 cfg_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Register port. Only the top_page register exists; the low address bits
    // select a byte lane and are not decoded.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_TOP_PAGE);
    assign prdata = (paddr[2] == REG_TOP_PAGE) ? {{(32-PAGE_W){1'b0}}, top_reg} : 32'd0;

    // Search bound: the smaller of top_page and the size of the map.
    assign lim = (top_reg < PAGE_W'(PAGES_CAP)) ? top_reg : PAGE_W'(PAGES_CAP);

    // The row being scanned is masked so that pages below the start of the
    // pass and pages at or above its limit look used.
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            eff_used[i] = rd_data_reg[i]
                || ((row_reg == from_reg[PAGE_W-1:BIT_W]) && (BIT_W'(i) < from_reg[BIT_W-1:0]))
                || ((row_reg == lm1_reg[PAGE_W-1:BIT_W]) && (BIT_W'(i) > lm1_reg[BIT_W-1:0]));
        end
    end

    assign deficit = cnt_reg - run_reg;

    bpa_word_scan u_scan (
        .used    (eff_used),
        .count   (cnt_reg),
        .deficit (deficit),
        .res     (sres)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-IDX_W){1'b0}}, out_base_reg};
    assign m_tuser  = out_status_reg;

    always_comb
    begin
        logic                in_mode;
        logic [PAGE_W-1:0]   in_idx;
        logic [PAGE_W-1:0]   in_cnt;
        logic [PAGE_W:0]     free_end;
        logic [PAGE_W:0]     free_hi;
        logic [PAGE_W-1:0]   second;
        logic [PAGE_W-1:0]   hit_page;
        logic [PAGE_W-1:0]   after;
        logic [PAGE_W-1:0]   base;
        logic [WORD_BITS-1:0] fmask;

        in_mode  = s_tuser[0];
        in_idx   = PAGE_W'(s_tdata[IDX_W-1:0]);
        in_cnt   = s_tdata[IDX_W+PAGE_W-1:IDX_W];
        free_end = (PAGE_W+1)'(in_idx) + (PAGE_W+1)'(in_cnt);
        free_hi  = (free_end > (PAGE_W+1)'(lim)) ? (PAGE_W+1)'(lim) : free_end;
        // Limit of the wrapped pass: pages below both the old cursor and the bound.
        second   = (cursor_reg < lim) ? cursor_reg : lim;
        hit_page = {row_reg, sres.hit_bit};
        after    = hit_page + PAGE_W'(1);
        base     = after - cnt_reg;

        for (int i = 0; i < WORD_BITS; i++)
        begin
            fmask[i] = ((fill_row_reg > fill_lo_reg[PAGE_W-1:BIT_W])
                        || (BIT_W'(i) >= fill_lo_reg[BIT_W-1:0]))
                    && ((fill_row_reg < fill_hm1_reg[PAGE_W-1:BIT_W])
                        || (BIT_W'(i) <= fill_hm1_reg[BIT_W-1:0]));
        end

        state_next      = state_reg;
        clr_row_next    = clr_row_reg;
        top_next        = cfg_we ? pwdata[PAGE_W-1:0] : top_reg;
        cursor_next     = cursor_reg;
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        pass_next       = pass_reg;
        row_next        = row_reg;
        from_next       = from_reg;
        lm1_next        = lm1_reg;
        run_next        = run_reg;
        fill_row_next   = fill_row_reg;
        fill_lo_next    = fill_lo_reg;
        fill_hm1_next   = fill_hm1_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_base_next   = out_base_reg;
        rd_addr         = RW'(row_reg);
        mem_we          = 1'b0;
        mem_waddr       = RW'(fill_row_reg);
        mem_wdata       = rd_data_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_row_reg;
                mem_wdata = '1;
                if (clr_row_reg == RW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + RW'(1);
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next     = in_mode;
                    cnt_next      = in_cnt;
                    res_base_next = '0;
                    run_next      = '0;
                    if ((in_cnt == '0) || ((in_mode == MODE_FREE) && (in_idx == '0)))
                    begin
                        res_status_next = STAT_IGNORED;
                        state_next      = S_DONE;
                    end
                    else if (in_mode == MODE_FREE)
                    begin
                        res_status_next = STAT_DONE;
                        if (free_hi > (PAGE_W+1)'(in_idx))
                        begin
                            fill_lo_next  = in_idx;
                            fill_hm1_next = PAGE_W'(free_hi - (PAGE_W+1)'(1));
                            fill_row_next = in_idx[PAGE_W-1:BIT_W];
                            state_next    = S_FILL_RD;
                        end
                        else
                        begin
                            // The whole run lies at or above the bound.
                            state_next = S_DONE;
                        end
                    end
                    else if (cursor_reg < lim)
                    begin
                        pass_next  = 1'b0;
                        from_next  = cursor_reg;
                        lm1_next   = lim - PAGE_W'(1);
                        row_next   = cursor_reg[PAGE_W-1:BIT_W];
                        state_next = S_SCAN_START;
                    end
                    else if (second != '0)
                    begin
                        // Cursor at or above the bound: only the wrapped pass.
                        pass_next  = 1'b1;
                        from_next  = '0;
                        lm1_next   = second - PAGE_W'(1);
                        row_next   = '0;
                        state_next = S_SCAN_START;
                    end
                    else
                    begin
                        res_status_next = STAT_NOMEM;
                        state_next      = S_DONE;
                    end
                end
            end

            S_SCAN_START:
            begin
                rd_addr    = RW'(row_reg);
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // The next row is fetched while this one is evaluated.
                rd_addr = RW'(ROW_W'(row_reg + ROW_W'(1)));
                if (sres.hit)
                begin
                    cursor_next     = after;
                    res_status_next = STAT_DONE;
                    res_base_next   = base[IDX_W-1:0];
                    fill_lo_next    = base;
                    fill_hm1_next   = hit_page;
                    fill_row_next   = base[PAGE_W-1:BIT_W];
                    state_next      = S_FILL_RD;
                end
                else if (row_reg == lm1_reg[PAGE_W-1:BIT_W])
                begin
                    if (!pass_reg && (second != '0))
                    begin
                        pass_next  = 1'b1;
                        from_next  = '0;
                        lm1_next   = second - PAGE_W'(1);
                        row_next   = '0;
                        run_next   = '0;
                        state_next = S_SCAN_START;
                    end
                    else
                    begin
                        res_status_next = STAT_NOMEM;
                        res_base_next   = '0;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    run_next = sres.all_free ? (run_reg + PAGE_W'(WORD_BITS))
                                             : PAGE_W'(sres.top_free);
                end
            end

            S_FILL_RD:
            begin
                rd_addr    = RW'(fill_row_reg);
                state_next = S_FILL_WR;
            end

            S_FILL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = RW'(fill_row_reg);
                mem_wdata = (mode_reg == MODE_ALLOC) ? (rd_data_reg | fmask)
                                                     : (rd_data_reg & ~fmask);
                if (fill_row_reg == fill_hm1_reg[PAGE_W-1:BIT_W])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    fill_row_next = fill_row_reg + ROW_W'(1);
                    state_next    = S_FILL_RD;
                end
            end

            S_DONE:
            begin
                // The result waits here only while the output register is full and not being taken.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_base_next   = res_base_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_row_reg    <= '0;
            top_reg        <= TOP_PAGE_RESET;
            cursor_reg     <= '0;
            mode_reg       <= MODE_ALLOC;
            cnt_reg        <= '0;
            pass_reg       <= 1'b0;
            row_reg        <= '0;
            from_reg       <= '0;
            lm1_reg        <= '0;
            run_reg        <= '0;
            fill_row_reg   <= '0;
            fill_lo_reg    <= '0;
            fill_hm1_reg   <= '0;
            res_status_reg <= STAT_DONE;
            res_base_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_DONE;
            out_base_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            top_reg        <= top_next;
            cursor_reg     <= cursor_next;
            mode_reg       <= mode_next;
            cnt_reg        <= cnt_next;
            pass_reg       <= pass_next;
            row_reg        <= row_next;
            from_reg       <= from_next;
            lm1_reg        <= lm1_next;
            run_reg        <= run_next;
            fill_row_reg   <= fill_row_next;
            fill_lo_reg    <= fill_lo_next;
            fill_hm1_reg   <= fill_hm1_next;
            res_status_reg <= res_status_next;
            res_base_reg   <= res_base_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_base_reg   <= out_base_next;
        end
    end

`ifndef ASSERT_OFF
    // The free run carried between rows is always short of the request.
    a_run_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (run_reg < cnt_reg))
        else $error("carried free run reached the requested count");

    // A marking or clearing pass never works on an empty or inverted range.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL_RD) |->
            ((fill_lo_reg <= fill_hm1_reg)
             && (fill_row_reg <= fill_hm1_reg[PAGE_W-1:BIT_W])))
        else $error("fill pass outside its page range");

    // The cursor only moves when a scan finds a run.
    a_cursor_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg != $past(cursor_reg)) |-> ($past(state_reg) == S_SCAN))
        else $error("cursor moved outside a successful scan");
`endif

endmodule

// ===== src/bpa_word_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator row scan
// Finds the lowest bit of one row at which a run of free pages reaches the
// requested count, given the free run carried in from the rows below.
// ----------------------------------------------------------------------------
module bpa_word_scan (
    input  logic [bpa_pkg::WORD_BITS-1:0] used,
    input  logic [bpa_pkg::PAGE_W-1:0]    count,
    input  logic [bpa_pkg::PAGE_W-1:0]    deficit,
    output bpa_pkg::scan_res_t            res
);
    import bpa_pkg::*;

    always_comb
    begin
        logic [WORD_BITS-1:0] gt;
        logic [WORD_BITS-1:0] win;
        logic [WORD_BITS-1:0] hit;
        logic [WORD_BITS-1:0] hit_iso;
        logic [WORD_BITS-1:0] rev;
        logic [WORD_BITS-1:0] rev_iso;
        logic [BIT_W-1:0]     hb;
        logic [BIT_W-1:0]     tf;

        // gt[d] tells whether a run ending at bit j still covers bit j-d.
        for (int d = 0; d < WORD_BITS; d++)
        begin
            gt[d] = (count > PAGE_W'(d));
        end

        // A run completes at bit j when its window inside this row is free
        // and the pages still missing fit below and at j.
        for (int j = 0; j < WORD_BITS; j++)
        begin
            win = '0;
            for (int i = 0; i <= j; i++)
            begin
                win[i] = gt[j-i];
            end
            hit[j] = ((used & win) == '0) && (deficit <= PAGE_W'(j + 1));
        end

        hit_iso = hit & (~hit + WORD_BITS'(1));
        hb = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (hit_iso[j])
            begin
                hb = hb | BIT_W'(j);
            end
        end

        // Free pages at the top of the row carry into the next row.
        for (int i = 0; i < WORD_BITS; i++)
        begin
            rev[i] = used[WORD_BITS-1-i];
        end
        rev_iso = rev & (~rev + WORD_BITS'(1));
        tf = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (rev_iso[i])
            begin
                tf = tf | BIT_W'(i);
            end
        end

        res.hit      = |hit;
        res.hit_bit  = hb;
        res.all_free = (used == '0);
        res.top_free = tf;
    end

endmodule
